@@ design/enc_pkg.sv @@
// shared constants and types of the edge node classifier
// no dependencies; used by the top level
package enc_pkg;

  localparam int DEF_MAX_WIDTH = 4096;

  localparam int PIXEL_W  = 8;
  localparam int CODE_W   = 4;
  localparam int TARGET_W = 8;
  localparam int LWIDTH_W = 13;
  localparam int HEIGHT_W = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_INDEX = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_WIDTH   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [TARGET_W-1:0] RST_TARGET_INDEX = 8'd0;
  localparam logic [LWIDTH_W-1:0] RST_LINE_WIDTH   = 13'd4096;
  localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT = 16'd4096;

  localparam logic [HEIGHT_W-1:0] MIN_DIM = 16'd2;

  // pixel in flight between line store read and output register
  typedef struct packed {
    logic cur;    // current pixel matches
    logic edge0;  // first row or first column
    logic hit;    // line store entry was written since reset
    logic last;   // last pixel of frame
  } s1_info_t;

endpackage

@@ design/edge_node_classifier.sv @@
// top level of the edge node classifier: counters, line store control, output register
// depends on enc_pkg and enc_ram
//
// One pixel is accepted every clock cycle while the output side keeps taking words;
// its node code word passes through the s1 register and the output register before
// it is offered. The rate is set by the one-bit line store,
// which is read and written at the same column in the cycle a pixel is accepted; its
// registered read feeds the code stage. The store needs no clearing pass after reset:
// a fill mark records how many leading columns have been written, and columns beyond
// it read as no match, so the block accepts pixels right out of reset.
module edge_node_classifier #(
  parameter int MAX_WIDTH = enc_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [enc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [enc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] pixel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [3:0] node_code, [7:4] zero
  output logic                           out_tlast
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (CW + 1 > enc_pkg::LWIDTH_W) ? CW + 1 : enc_pkg::LWIDTH_W;
  localparam int HW = enc_pkg::HEIGHT_W;

  logic [enc_pkg::TARGET_W-1:0] target_r;
  logic [enc_pkg::LWIDTH_W-1:0] lwidth_r;
  logic [HW-1:0]                height_r;

  logic [CW-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          left_r, left_nxt;
  logic          upleft_r, upleft_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  enc_pkg::s1_info_t s1_r, s1_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [enc_pkg::CODE_W-1:0] code_r, code_nxt;
  logic              last_r, last_nxt;

  logic          s1_adv;
  logic          in_fire;
  logic          cur;
  logic          up;
  logic          last_col;
  logic          last_row;
  logic [EW-1:0] eff_w;
  logic [EW-1:0] lw_ext;
  logic [HW-1:0] eff_h;
  logic          ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= enc_pkg::RST_TARGET_INDEX;
      lwidth_r <= enc_pkg::RST_LINE_WIDTH;
      height_r <= enc_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        enc_pkg::REG_TARGET_INDEX: target_r <= cfg_wr_data[enc_pkg::TARGET_W-1:0];
        enc_pkg::REG_LINE_WIDTH:   lwidth_r <= cfg_wr_data[enc_pkg::LWIDTH_W-1:0];
        enc_pkg::REG_FRAME_HEIGHT: height_r <= cfg_wr_data[HW-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign cur    = (in_tdata == target_r);
  assign lw_ext = EW'(lwidth_r);

  always_comb begin
    if (lw_ext < EW'(2)) begin
      eff_w = EW'(2);
    end else if (lw_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = lw_ext;
    end
    eff_h = (height_r < enc_pkg::MIN_DIM) ? enc_pkg::MIN_DIM : height_r;
  end

  assign last_col = (EW'(col_r) + EW'(1)) >= eff_w;
  assign last_row = ((HW + 1)'(row_r) + (HW + 1)'(1)) >= (HW + 1)'(eff_h);

  enc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col_r),
    .wdata (cur),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign up = s1_r.hit & ram_rdata;

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    fill_nxt      = fill_r;
    left_nxt      = left_r;
    upleft_nxt    = upleft_r;
    s1_valid_nxt  = s1_valid_r;
    s1_nxt        = s1_r;
    out_valid_nxt = out_valid_r;
    code_nxt      = code_r;
    last_nxt      = last_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      s1_valid_nxt  = 1'b0;
      code_nxt      = s1_r.edge0 ? '0 : {left_r, s1_r.cur, up, upleft_r};
      last_nxt      = s1_r.last;
      upleft_nxt    = up;
      left_nxt      = s1_r.cur;
    end

    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      s1_nxt.cur   = cur;
      s1_nxt.edge0 = (row_r == '0) || (col_r == '0);
      s1_nxt.hit   = FW'(col_r) < fill_r;
      s1_nxt.last  = last_col && last_row;
      // columns are always written in order from zero, so a mark covers them
      if (FW'(col_r) == fill_r) begin
        fill_nxt = fill_r + FW'(1);
      end
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + HW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      fill_r      <= '0;
      left_r      <= 1'b0;
      upleft_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      fill_r      <= fill_nxt;
      left_r      <= left_nxt;
      upleft_r    <= upleft_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r   <= s1_nxt;
    code_r <= code_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, code_r};
  assign out_tlast  = last_r;

endmodule

@@ design/enc_ram.sv @@
// generic single-write, single-read synchronous ram with registered read
// read-first on a same-address write; no dependencies
module enc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
